FILE: rtl/mnq_pkg.sv
// mnq_pkg: shared types, constants and helper functions for the midi note queue block
// depends on nothing; imported by every module of the block but mnq_ram
`default_nettype none

package mnq_pkg;

    // default sizes, handed down through the top-level parameters
    localparam int CHANNELS_DEF    = 16;
    localparam int NOTES_DEF       = 128;
    localparam int QUEUE_DEPTH_DEF = 256;

    // controller numbers per channel (one table row)
    localparam int CTRL_COUNT = 128;

    // fixed values
    localparam logic [7:0] EMPTY_NOTE = 8'd255;
    localparam logic [6:0] MAX_MIDI   = 7'd127;

    // controllers with a non-zero reset value
    localparam logic [6:0] CC_VOLUME         = 7'd7;
    localparam logic [6:0] CC_PAN            = 7'd10;
    localparam logic [6:0] CC_EXPRESSION     = 7'd11;
    localparam logic [6:0] CC_VOLUME_DEF     = 7'd100;
    localparam logic [6:0] CC_PAN_DEF        = 7'd64;
    localparam logic [6:0] CC_EXPRESSION_DEF = 7'd127;

    // request codes
    typedef enum logic [2:0] {
        REQ_NOTE_ON  = 3'd0,
        REQ_NOTE_OFF = 3'd1,
        REQ_POP_ON   = 3'd2,
        REQ_POP_OFF  = 3'd3,
        REQ_SET_CTRL = 3'd4,
        REQ_QUERY    = 3'd5
    } req_kind_t;

    // decoded request as handed to the queue and table units
    typedef struct packed {
        req_kind_t  kind;
        logic [3:0] channel;
        logic [6:0] note_index;
        logic [6:0] level;
        logic       ch_ok;
        logic       note_ok;
    } req_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // saturate an 8-bit value to the 7-bit midi range
    function automatic logic [6:0] clamp_midi(input logic [7:0] v);
        logic [6:0] r;
        r = v[7] ? MAX_MIDI : v[6:0];
        return r;
    endfunction

    // controller value after reset
    function automatic logic [6:0] ctrl_default(input logic [6:0] num);
        logic [6:0] r;
        if (num == CC_VOLUME)
            r = CC_VOLUME_DEF;
        else if (num == CC_PAN)
            r = CC_PAN_DEF;
        else if (num == CC_EXPRESSION)
            r = CC_EXPRESSION_DEF;
        else
            r = 7'd0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mnq_ram.sv
// mnq_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module mnq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/mnq_queue.sv
// mnq_queue: note-on and note-off ring queues, pointer file in flops, slots in ram
// depends on mnq_pkg and mnq_ram
`default_nettype none

module mnq_queue #(
    parameter int CHANNELS    = mnq_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = mnq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         rd_en,
    input  wire mnq_pkg::req_t in_req,
    input  wire logic         exec_en,
    input  wire mnq_pkg::req_t ex_req,
    output logic [7:0]        popped_note
);

    import mnq_pkg::*;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QW         = CH_W + 1;
    localparam int Q_COUNT    = 2 ** QW;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QMEM_DEPTH = 2 ** (QW + PTR_W);

    logic [PTR_W-1:0]  rd_ptr_reg [Q_COUNT];
    logic [PTR_W-1:0]  wr_ptr_reg [Q_COUNT];
    logic [FILL_W-1:0] fill_reg   [Q_COUNT];

    logic [QW-1:0]     in_q;
    logic [QW-1:0]     ex_q;
    logic              ex_off;
    logic              ex_push;
    logic              ex_pop;
    logic              ex_full;
    logic [PTR_W-1:0]  cur_rd;
    logic [PTR_W-1:0]  cur_wr;
    logic [FILL_W-1:0] cur_fill;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [FILL_W-1:0] fill_next;
    logic [6:0]        slot_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    // queue selection: read side from the incoming request, update side from the held one
    assign in_q    = {in_req.kind == REQ_POP_OFF, in_req.channel[CH_W-1:0]};
    assign ex_off  = (ex_req.kind == REQ_NOTE_OFF) || (ex_req.kind == REQ_POP_OFF);
    assign ex_q    = {ex_off, ex_req.channel[CH_W-1:0]};
    assign cur_rd   = rd_ptr_reg[ex_q];
    assign cur_wr   = wr_ptr_reg[ex_q];
    assign cur_fill = fill_reg[ex_q];
    assign ex_full  = (cur_fill == FILL_W'(QUEUE_DEPTH));

    assign ex_push = ((ex_req.kind == REQ_NOTE_ON) || (ex_req.kind == REQ_NOTE_OFF))
                     && ex_req.ch_ok && ex_req.note_ok;
    assign ex_pop  = ((ex_req.kind == REQ_POP_ON) || (ex_req.kind == REQ_POP_OFF))
                     && ex_req.ch_ok && (cur_fill != '0);

    // pointer and fill update; a push into a full queue drops the oldest slot
    always_comb
    begin
        rd_ptr_next = cur_rd;
        wr_ptr_next = cur_wr;
        fill_next   = cur_fill;
        if (ex_push)
        begin
            wr_ptr_next = ptr_inc(cur_wr);
            if (ex_full)
                rd_ptr_next = ptr_inc(cur_rd);
            else
                fill_next = cur_fill + 1'b1;
        end
        else if (ex_pop)
        begin
            rd_ptr_next = ptr_inc(cur_rd);
            fill_next   = cur_fill - 1'b1;
        end
    end

    // pointer file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Q_COUNT; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
        end
        else if (exec_en && (ex_push || ex_pop))
        begin
            rd_ptr_reg[ex_q] <= rd_ptr_next;
            wr_ptr_reg[ex_q] <= wr_ptr_next;
            fill_reg[ex_q]   <= fill_next;
        end
    end

    // slot storage: head read at accept, push written during execute
    mnq_ram #(
        .WIDTH (7),
        .DEPTH (QMEM_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (exec_en && ex_push),
        .waddr ({ex_q, cur_wr}),
        .wdata (ex_req.note_index),
        .re    (rd_en),
        .raddr ({in_q, rd_ptr_reg[in_q]}),
        .rdata (slot_rdata)
    );

    assign popped_note = ex_pop ? {1'b0, slot_rdata} : EMPTY_NOTE;

endmodule

`default_nettype wire

FILE: rtl/mnq_tables.sv
// mnq_tables: velocity and controller tables in one ram, active flags in a second ram
// depends on mnq_pkg and mnq_ram; runs a clearing pass over both rams after reset
`default_nettype none

module mnq_tables #(
    parameter int CHANNELS = mnq_pkg::CHANNELS_DEF,
    parameter int NOTES    = mnq_pkg::NOTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire mnq_pkg::req_t in_req,
    input  wire logic          exec_en,
    input  wire mnq_pkg::req_t ex_req,
    output logic               busy,
    output logic [6:0]         velocity,
    output logic               note_active,
    output logic [6:0]         controller_value
);

    import mnq_pkg::*;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NOTE_W     = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam int TBL_ADDR_W = CH_W + 7;
    localparam int TBL_DEPTH  = 2 ** TBL_ADDR_W;
    localparam int ACT_DEPTH  = 2 ** NOTE_W;
    localparam int CLEAR_LAST = CHANNELS * CTRL_COUNT - 1;

    logic                  clear_reg;
    logic                  clear_next;
    logic [TBL_ADDR_W-1:0] clear_cnt_reg;
    logic [TBL_ADDR_W-1:0] clear_cnt_next;

    logic [13:0]           tbl_rdata;
    logic                  act_rdata;
    logic [6:0]            vel_new;
    logic [6:0]            ctrl_new;
    logic                  act_cur;
    logic                  act_new;
    logic                  tbl_wr;
    logic                  act_wr;
    logic                  ram_we;
    logic [TBL_ADDR_W-1:0] ram_waddr;
    logic [13:0]           ram_wdata;
    logic                  act_we;
    logic [NOTE_W-1:0]     act_waddr;
    logic                  act_wdata;

    // clearing pass sequencing
    always_comb
    begin
        clear_next     = clear_reg;
        clear_cnt_next = clear_cnt_reg;
        if (clear_reg)
        begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == TBL_ADDR_W'(CLEAR_LAST))
                clear_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    assign busy = clear_reg;

    // read-modify of the held entry
    assign act_cur = ex_req.note_ok ? act_rdata : 1'b0;

    always_comb
    begin
        vel_new  = tbl_rdata[13:7];
        ctrl_new = tbl_rdata[6:0];
        act_new  = act_cur;
        tbl_wr   = 1'b0;
        act_wr   = 1'b0;
        unique case (ex_req.kind)
            REQ_NOTE_ON:
            begin
                if (ex_req.ch_ok && ex_req.note_ok)
                begin
                    vel_new = ex_req.level;
                    act_new = 1'b1;
                    tbl_wr  = 1'b1;
                    act_wr  = 1'b1;
                end
            end
            REQ_NOTE_OFF:
            begin
                if (ex_req.ch_ok && ex_req.note_ok)
                begin
                    vel_new = 7'd0;
                    act_new = 1'b0;
                    tbl_wr  = 1'b1;
                    act_wr  = 1'b1;
                end
            end
            REQ_SET_CTRL:
            begin
                if (ex_req.ch_ok)
                begin
                    ctrl_new = ex_req.level;
                    tbl_wr   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // active flag ram, shared by all channels: clearing pass or write-back
    assign act_we    = clear_reg || (exec_en && act_wr);
    assign act_waddr = clear_reg ? clear_cnt_reg[NOTE_W-1:0]
                                 : ex_req.note_index[NOTE_W-1:0];
    assign act_wdata = clear_reg ? 1'b0 : act_new;

    mnq_ram #(
        .WIDTH (1),
        .DEPTH (ACT_DEPTH)
    ) u_active (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .re    (rd_en),
        .raddr (in_req.note_index[NOTE_W-1:0]),
        .rdata (act_rdata)
    );

    // ram write: clearing pass or write-back
    assign ram_we    = clear_reg || (exec_en && tbl_wr);
    assign ram_waddr = clear_reg ? clear_cnt_reg
                                 : {ex_req.channel[CH_W-1:0], ex_req.note_index};
    assign ram_wdata = clear_reg ? {7'd0, ctrl_default(clear_cnt_reg[6:0])}
                                 : {vel_new, ctrl_new};

    mnq_ram #(
        .WIDTH (14),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr ({in_req.channel[CH_W-1:0], in_req.note_index}),
        .rdata (tbl_rdata)
    );

    // values after the item, zero where the address is out of range
    assign velocity         = (ex_req.ch_ok && ex_req.note_ok) ? vel_new : 7'd0;
    assign note_active      = ex_req.note_ok ? act_new : 1'b0;
    assign controller_value = ex_req.ch_ok ? ctrl_new : 7'd0;

endmodule

`default_nettype wire

FILE: rtl/midi_note_queue_and_state_table.sv
// Midi note queue and state table. Requests arrive on the input channel
// (in_valid/in_ready with req_type, channel, note_index, value); each gives
// exactly one transaction on the output channel (out_valid/out_ready with
// popped_note, velocity, note_active, controller_value).
// Each item has an accept cycle, which issues reads of the queue slot ram,
// the velocity/controller ram and the active flag ram, and an execute
// cycle, which modifies and writes back and loads the output register. One
// item is in flight at a time, a limit set by the read-then-write of the
// synchronous rams. out_valid rises with the output register load as execute
// ends; execute waits while that register still holds an untaken result.
// After reset the block clears the velocity/controller ram one entry a cycle
// over CHANNELS*128 entries (2048 by default), with in_ready low throughout.
// A stalled receiver leaves the result in the output register while the next
// request is taken; that request then waits in execute until the register
// is free.
// depends on mnq_pkg, mnq_queue, mnq_tables, mnq_ram
`default_nettype none

module midi_note_queue_and_state_table #(
    parameter int CHANNELS    = mnq_pkg::CHANNELS_DEF,
    parameter int NOTES       = mnq_pkg::NOTES_DEF,
    parameter int QUEUE_DEPTH = mnq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] req_type,
    input  wire logic [3:0] channel,
    input  wire logic [6:0] note_index,
    input  wire logic [7:0] value,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      popped_note,
    output logic [6:0]      velocity,
    output logic            note_active,
    output logic [6:0]      controller_value
);

    import mnq_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    req_t       in_req;
    req_t       req_reg;
    req_kind_t  in_kind;
    logic [6:0] in_level;
    logic       accept;
    logic       exec_en;
    logic       busy;

    logic [7:0] q_popped;
    logic [6:0] t_velocity;
    logic       t_active;
    logic [6:0] t_ctrl;

    logic       out_valid_reg;
    logic [7:0] popped_reg;
    logic [6:0] velocity_reg;
    logic       active_reg;
    logic [6:0] ctrl_reg;

    // request decode; a zero-velocity note-on becomes a note-off
    assign in_level = clamp_midi(value);

    always_comb
    begin
        unique case (req_type)
            REQ_NOTE_ON:  in_kind = (in_level == 7'd0) ? REQ_NOTE_OFF : REQ_NOTE_ON;
            REQ_NOTE_OFF: in_kind = REQ_NOTE_OFF;
            REQ_POP_ON:   in_kind = REQ_POP_ON;
            REQ_POP_OFF:  in_kind = REQ_POP_OFF;
            REQ_SET_CTRL: in_kind = REQ_SET_CTRL;
            default:      in_kind = REQ_QUERY;
        endcase
    end

    assign in_req.kind       = in_kind;
    assign in_req.channel    = channel;
    assign in_req.note_index = note_index;
    assign in_req.level      = in_level;
    assign in_req.ch_ok      = ({1'b0, channel} < 5'(CHANNELS));
    assign in_req.note_ok    = ({1'b0, note_index} < 8'(NOTES));

    assign accept = in_valid && in_ready;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (exec_en) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        exec_en  = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = !busy;
            ST_EXEC: exec_en  = !out_valid_reg || out_ready;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // held request for the execute cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_req;
    end

    mnq_queue #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (accept),
        .in_req      (in_req),
        .exec_en     (exec_en),
        .ex_req      (req_reg),
        .popped_note (q_popped)
    );

    mnq_tables #(
        .CHANNELS (CHANNELS),
        .NOTES    (NOTES)
    ) u_tables (
        .clk              (clk),
        .rst_n            (rst_n),
        .rd_en            (accept),
        .in_req           (in_req),
        .exec_en          (exec_en),
        .ex_req           (req_reg),
        .busy             (busy),
        .velocity         (t_velocity),
        .note_active      (t_active),
        .controller_value (t_ctrl)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec_en)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            popped_reg   <= q_popped;
            velocity_reg <= t_velocity;
            active_reg   <= t_active;
            ctrl_reg     <= t_ctrl;
        end
    end

    assign out_valid        = out_valid_reg;
    assign popped_note      = popped_reg;
    assign velocity         = velocity_reg;
    assign note_active      = active_reg;
    assign controller_value = ctrl_reg;

    // one item in flight: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request accepted while another is in execute");

    // no request is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("request accepted during table clearing");

    // execute always leaves a result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_en |=> out_valid_reg)
        else $error("execute did not load the output register");

    // a blocked execute holds its state and the pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) && out_valid_reg && !out_ready
        |=> (state_reg == ST_EXEC) && $stable(popped_reg) && $stable(ctrl_reg))
        else $error("execute or pending result changed while output stalled");

endmodule

`default_nettype wire

FILE: sim/midi_note_queue_and_state_table_test.sv
// testbench for midi_note_queue_and_state_table: directed and random midi requests,
// results checked against a predictor of the queues and tables held in a scoreboard class
// depends on mnq_pkg and the rtl of the block
`timescale 1ns / 100ps

module midi_note_queue_and_state_table_test;

    import mnq_pkg::*;

    // spare request codes, decoded as query by the block
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int CH_COUNT   = CHANNELS_DEF;
    localparam int NOTE_COUNT = NOTES_DEF;
    localparam int QDEPTH     = QUEUE_DEPTH_DEF;

    localparam int IDLE_PCT         = 18;
    localparam int RECV_HOLD_CYCLES = 500;
    // covers the clearing pass after reset or the long receiver hold-off, with margin
    localparam int WATCHDOG_LIMIT   = 8000;

    typedef struct {
        logic [7:0] popped;
        logic [6:0] vel;
        logic       act;
        logic [6:0] ctrl;
    } note_result_t;

    // queue, velocity, active and controller state as the block should hold it
    class note_state_tracker;
        bit [6:0]     slot_store [2][CH_COUNT][QDEPTH];
        int           read_ptr [2*CH_COUNT];
        int           write_ptr [2*CH_COUNT];
        int           fill [2*CH_COUNT];
        bit [6:0]     vel_table [CH_COUNT][NOTE_COUNT];
        bit           active [NOTE_COUNT];
        bit [6:0]     ctrl_table [CH_COUNT][CTRL_COUNT];
        note_result_t pending_results[$];
        int           mismatches;

        function new();
            for (int ch = 0; ch < CH_COUNT; ch++)
            begin
                ctrl_table[ch][CC_VOLUME]     = CC_VOLUME_DEF;
                ctrl_table[ch][CC_PAN]        = CC_PAN_DEF;
                ctrl_table[ch][CC_EXPRESSION] = CC_EXPRESSION_DEF;
            end
            mismatches = 0;
        endfunction

        // full queue drops its oldest entry before the write
        function void push_note(int off, int ch, bit [6:0] note);
            int q;
            q = off * CH_COUNT + ch;
            if (fill[q] >= QDEPTH)
            begin
                read_ptr[q] = (read_ptr[q] + 1) % QDEPTH;
                fill[q]     = QDEPTH - 1;
            end
            slot_store[off][ch][write_ptr[q]] = note;
            write_ptr[q] = (write_ptr[q] + 1) % QDEPTH;
            fill[q]      = fill[q] + 1;
        endfunction

        function bit [7:0] pop_note(int off, int ch);
            int       q;
            bit [7:0] note;
            q = off * CH_COUNT + ch;
            if (fill[q] == 0)
                return EMPTY_NOTE;
            note        = {1'b0, slot_store[off][ch][read_ptr[q]]};
            read_ptr[q] = (read_ptr[q] + 1) % QDEPTH;
            fill[q]     = fill[q] - 1;
            return note;
        endfunction

        // apply one accepted request and queue the result it must give
        function void log_request(logic [2:0] kind, logic [3:0] ch, logic [6:0] idx,
                                  logic [7:0] val);
            bit [2:0]     k;
            bit [6:0]     lvl;
            note_result_t r;
            k        = kind;
            lvl      = (val > MAX_MIDI) ? MAX_MIDI : val[6:0];
            r.popped = EMPTY_NOTE;
            // note-on at zero velocity is a note-off
            if (k == REQ_NOTE_ON && lvl == 7'd0)
                k = REQ_NOTE_OFF;
            case (k)
                REQ_NOTE_ON:
                begin
                    push_note(0, ch, idx);
                    active[idx]        = 1'b1;
                    vel_table[ch][idx] = lvl;
                end
                REQ_NOTE_OFF:
                begin
                    push_note(1, ch, idx);
                    active[idx]        = 1'b0;
                    vel_table[ch][idx] = 7'd0;
                end
                REQ_POP_ON:   r.popped = pop_note(0, ch);
                REQ_POP_OFF:  r.popped = pop_note(1, ch);
                REQ_SET_CTRL: ctrl_table[ch][idx] = lvl;
                default:      ;
            endcase
            r.vel  = vel_table[ch][idx];
            r.act  = active[idx];
            r.ctrl = ctrl_table[ch][idx];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [7:0] popped, logic [6:0] vel, logic act,
                                   logic [6:0] ctrl);
            note_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                mismatches++;
                return;
            end
            e = pending_results.pop_front();
            if (popped !== e.popped)
            begin
                $error("popped_note: expected %0d, actual %0d", e.popped, popped);
                mismatches++;
            end
            if (vel !== e.vel)
            begin
                $error("velocity: expected %0d, actual %0d", e.vel, vel);
                mismatches++;
            end
            if (act !== e.act)
            begin
                $error("note_active: expected %0d, actual %0d", e.act, act);
                mismatches++;
            end
            if (ctrl !== e.ctrl)
            begin
                $error("controller_value: expected %0d, actual %0d", e.ctrl, ctrl);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] req_type;
    logic [3:0] channel;
    logic [6:0] note_index;
    logic [7:0] value;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] popped_note;
    logic [6:0] velocity;
    logic       note_active;
    logic [6:0] controller_value;

    bit send_gaps     = 1'b1;
    bit recv_gaps     = 1'b1;
    bit stall_request = 1'b0;
    int quiet_cycles  = 0;

    note_state_tracker tracker = new();

    midi_note_queue_and_state_table uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .channel          (channel),
        .note_index       (note_index),
        .value            (value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .popped_note      (popped_note),
        .velocity         (velocity),
        .note_active      (note_active),
        .controller_value (controller_value)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one request from a falling edge and hold it until the transaction
    task automatic send_req(input logic [2:0] kind, input logic [3:0] ch,
                            input logic [6:0] idx, input logic [7:0] val);
        while (send_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        channel    <= ch;
        note_index <= idx;
        value      <= val;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.log_request(kind, ch, idx, val);
        @(negedge clk);
    endtask

    // drop valid and wait until every outstanding result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending_results.size() != 0);
    endtask

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return REQ_NOTE_ON;
        else if (r < 50)
            return REQ_NOTE_OFF;
        else if (r < 65)
            return REQ_POP_ON;
        else if (r < 75)
            return REQ_POP_OFF;
        else if (r < 85)
            return REQ_SET_CTRL;
        else if (r < 95)
            return REQ_QUERY;
        else if (r < 98)
            return REQ_SPARE_6;
        return REQ_SPARE_7;
    endfunction

    // velocity or controller value, biased towards the clamp boundary
    function automatic logic [7:0] pick_level();
        case ($urandom_range(15))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd127;
            3:       return 8'd128;
            4:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mixed requests; narrow mode favours the channels whose queues were filled
    task automatic send_random(input int count, input bit narrow);
        logic [3:0] ch;
        for (int i = 0; i < count; i++)
        begin
            if (narrow && $urandom_range(1))
                ch = $urandom_range(1) ? 4'd9 : 4'd12;
            else
                ch = 4'($urandom_range(15));
            send_req(pick_kind(), ch, 7'($urandom_range(127)), pick_level());
        end
    endtask

    // push past the queue depth so the oldest entries drop, then pop some back
    task automatic flood_queue(input logic [2:0] kind, input logic [3:0] ch,
                               input int pushes);
        logic [7:0] lvl;
        logic [2:0] pop_kind;
        pop_kind = (kind == REQ_NOTE_ON) ? REQ_POP_ON : REQ_POP_OFF;
        for (int i = 0; i < pushes; i++)
        begin
            lvl = (kind == REQ_NOTE_ON) ? 8'($urandom_range(255, 1)) : pick_level();
            if ($urandom_range(9) == 0)
                send_req(REQ_QUERY, ch, 7'($urandom_range(127)), lvl);
            else
                send_req(kind, ch, 7'($urandom_range(127)), lvl);
        end
        for (int i = 0; i < 40; i++)
            send_req(pop_kind, ch, 7'($urandom_range(127)), pick_level());
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (RECV_HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_ready <= !(recv_gaps && $urandom_range(99) < IDLE_PCT);
        end
    end

    // result monitor and watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready === 1'b1)
            tracker.check_result(popped_note, velocity, note_active, controller_value);
        if ((in_valid === 1'b1 && in_ready === 1'b1) ||
            (out_valid === 1'b1 && out_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_QUERY;
        channel    <= 4'd0;
        note_index <= 7'd0;
        value      <= 8'd0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, zero velocity, clamping, empty pops, defaults
        send_req(REQ_QUERY,    4'd3,  CC_VOLUME,     8'd0);
        send_req(REQ_QUERY,    4'd3,  CC_PAN,        8'd255);
        send_req(REQ_QUERY,    4'd15, CC_EXPRESSION, 8'd0);
        send_req(REQ_POP_ON,   4'd15, 7'd0,          8'd0);
        send_req(REQ_POP_OFF,  4'd0,  7'd127,        8'd255);
        send_req(REQ_NOTE_ON,  4'd0,  7'd0,          8'd0);
        send_req(REQ_NOTE_ON,  4'd15, 7'd127,        8'd255);
        send_req(REQ_NOTE_ON,  4'd0,  7'd0,          8'd1);
        send_req(REQ_NOTE_ON,  4'd0,  7'd64,         8'd127);
        send_req(REQ_NOTE_ON,  4'd0,  7'd65,         8'd128);
        send_req(REQ_NOTE_OFF, 4'd15, 7'd127,        8'd200);
        send_req(REQ_QUERY,    4'd15, 7'd127,        8'd0);
        send_req(REQ_POP_ON,   4'd15, 7'd127,        8'd0);
        send_req(REQ_POP_ON,   4'd15, 7'd127,        8'd0);
        send_req(REQ_POP_OFF,  4'd15, 7'd0,          8'd0);
        send_req(REQ_POP_OFF,  4'd0,  7'd0,          8'd0);
        send_req(REQ_POP_OFF,  4'd0,  7'd0,          8'd0);
        send_req(REQ_SET_CTRL, 4'd3,  CC_VOLUME,     8'd200);
        send_req(REQ_SET_CTRL, 4'd3,  CC_PAN,        8'd0);
        send_req(REQ_SET_CTRL, 4'd15, 7'd127,        8'd127);
        send_req(REQ_SET_CTRL, 4'd0,  7'd0,          8'd255);
        send_req(REQ_SPARE_6,  4'd3,  CC_VOLUME,     8'd255);
        send_req(REQ_SPARE_7,  4'd0,  7'd64,         8'd255);
        send_req(REQ_QUERY,    4'd0,  7'd0,          8'd0);

        // random mix over all channels
        send_random(560, 1'b0);
        wait_drained();

        // long hold-off on the receiver while the sender floods without gaps
        send_gaps     = 1'b0;
        recv_gaps     = 1'b0;
        stall_request = 1'b1;
        flood_queue(REQ_NOTE_ON,  4'd9,  310);
        flood_queue(REQ_NOTE_OFF, 4'd12, 300);

        // random mix again, leaning on the flooded channels
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_random(200, 1'b1);

        wait_drained();
        repeat (8) @(negedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: midi_note_queue_and_state_table.f
rtl/mnq_pkg.sv
rtl/mnq_ram.sv
rtl/mnq_queue.sv
rtl/mnq_tables.sv
rtl/midi_note_queue_and_state_table.sv
sim/midi_note_queue_and_state_table_test.sv
